// ===== src/weighted_moving_average_macros.svh =====
// Assertion macros used by the weighted moving average RTL.
`ifndef WEIGHTED_MOVING_AVERAGE_MACROS_SVH
`define WEIGHTED_MOVING_AVERAGE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define WMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define WMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/wma_pkg.sv =====
// Types and constants for the weighted moving average block.
`timescale 1ns / 1ps
package wma_pkg;

  // Field and accumulator widths
  localparam int LEN_W          = 9;
  localparam int SAMPLE_W       = 32;
  localparam int PLAIN_W        = 40;
  localparam int WSUM_W         = 48;
  localparam int DEN_W          = 2 * LEN_W - 1;
  localparam int PROD_W         = SAMPLE_W + LEN_W;
  localparam int MAX_WINDOW_DEF = 256;

  // Input queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One input item
  typedef struct packed {
    logic [SAMPLE_W-1:0] price;
    logic                start_series;
  } item_t;

  // Queue head toward the back part
  typedef struct packed {
    logic  valid;
    item_t item;
  } item_req_t;

  // One result item
  typedef struct packed {
    logic [SAMPLE_W-1:0] wma_value;
    logic                valid_res;
  } result_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [WSUM_W-1:0] dividend;
    logic [DEN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WSUM_W-1:0] quotient;
  } div_rsp_t;

  // Back part sequencer
  typedef enum logic [1:0] {
    B_IDLE,
    B_UPDATE,
    B_DIV,
    B_OUT
  } back_state_e;

endpackage

// ===== src/wma_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module wma_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/wma_front.sv =====
// Front part: accepts input items into a short queue toward the back part.
`timescale 1ns / 1ps
module wma_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  wma_pkg::item_t       s_item_i,
  output wma_pkg::item_req_t   q_o,
  input  logic                 q_ready_i
);

  logic [wma_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [wma_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [wma_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  wma_pkg::item_t             buf_q [wma_pkg::QUEUE_DEPTH];
  logic                       push, pop;

  assign s_ready_o = (cnt_q != wma_pkg::QCNT_W'(wma_pkg::QUEUE_DEPTH));
  assign push      = s_valid_i & s_ready_o;
  assign q_o.valid = (cnt_q != '0);
  assign q_o.item  = buf_q[rd_ptr_q];
  assign pop       = q_o.valid & q_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == wma_pkg::QPTR_W'(wma_pkg::QUEUE_DEPTH - 1)) ? '0
               : wr_ptr_q + wma_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == wma_pkg::QPTR_W'(wma_pkg::QUEUE_DEPTH - 1)) ? '0
               : rd_ptr_q + wma_pkg::QPTR_W'(1);
    end
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + wma_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - wma_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= s_item_i;
    end
  end

endmodule

// ===== src/wma_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wma_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wma_pkg::div_req_t req_i,
  output wma_pkg::div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(wma_pkg::WSUM_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [wma_pkg::DEN_W-1:0]   rem_q, rem_d;
  logic [wma_pkg::DEN_W-1:0]   div_q, div_d;
  logic [wma_pkg::WSUM_W-1:0]  quo_q, quo_d;
  logic [wma_pkg::DEN_W+1:0]   diff;
  logic                        borrow;

  // Trial subtraction of the divisor from the shifted remainder
  assign diff   = {1'b0, rem_q, quo_q[wma_pkg::WSUM_W-1]} - {2'b00, div_q};
  assign borrow = diff[wma_pkg::DEN_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = borrow ? {rem_q[wma_pkg::DEN_W-2:0], quo_q[wma_pkg::WSUM_W-1]}
                     : diff[wma_pkg::DEN_W-1:0];
      quo_d = {quo_q[wma_pkg::WSUM_W-2:0], ~borrow};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(wma_pkg::WSUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== src/wma_core.sv =====
// Back part: sample window, running sums, divider control and output register.
`timescale 1ns / 1ps
`include "weighted_moving_average_macros.svh"
module wma_core #(
  parameter int MaxWindow = wma_pkg::MAX_WINDOW_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic [wma_pkg::LEN_W-1:0] len_i,
  input  logic [wma_pkg::DEN_W-1:0] denom_i,
  input  wma_pkg::item_req_t        q_i,
  output logic                      q_ready_o,
  output wma_pkg::div_req_t         div_req_o,
  input  wma_pkg::div_rsp_t         div_rsp_i,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output wma_pkg::result_t          m_result_o
);

  localparam int PTR_W = $clog2(MaxWindow);

  wma_pkg::back_state_e         state_q, state_d;
  wma_pkg::item_t               cur_q, cur_d;
  logic [wma_pkg::PROD_W-1:0]   prod_q, prod_d;
  logic [PTR_W-1:0]             ptr_q, ptr_d;
  logic [wma_pkg::LEN_W-1:0]    fill_q, fill_d;
  logic [wma_pkg::PLAIN_W-1:0]  plain_q, plain_d;
  logic [wma_pkg::WSUM_W-1:0]   wsum_q, wsum_d;
  wma_pkg::result_t             res_q, res_d;
  wma_pkg::result_t             out_q, out_d;
  logic                         out_valid_q, out_valid_d;

  logic                         pop;
  logic [wma_pkg::LEN_W-1:0]    fill_eff, mult, fill_new, ptr_ext, ptr_inc;
  logic                         filling;
  logic [PTR_W-1:0]             raddr;
  logic [wma_pkg::SAMPLE_W-1:0] oldest;

  assign q_ready_o = (state_q == wma_pkg::B_IDLE);
  assign pop       = q_i.valid & q_ready_o;

  // Weight for the incoming sample, seen with a series restart applied
  assign fill_eff = q_i.item.start_series ? '0 : fill_q;
  assign mult     = (fill_eff < len_i) ? fill_eff + wma_pkg::LEN_W'(1) : len_i;
  assign raddr    = q_i.item.start_series ? '0 : ptr_q;

  // Window position and fill state
  assign ptr_ext  = wma_pkg::LEN_W'(ptr_q);
  assign ptr_inc  = ptr_ext + wma_pkg::LEN_W'(1);
  assign filling  = (fill_q < len_i);
  assign fill_new = filling ? fill_q + wma_pkg::LEN_W'(1) : fill_q;

  wma_ram #(
    .Width (wma_pkg::SAMPLE_W),
    .Depth (MaxWindow)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (state_q == wma_pkg::B_UPDATE),
    .waddr_i (ptr_q),
    .wdata_i (cur_q.price),
    .re_i    (pop),
    .raddr_i (raddr),
    .rdata_o (oldest)
  );

  // Sequencer: next state, sums and results
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    prod_d      = prod_q;
    ptr_d       = ptr_q;
    fill_d      = fill_q;
    plain_d     = plain_q;
    wsum_d      = wsum_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~m_ready_i;
    div_req_o.start    = 1'b0;
    div_req_o.divisor  = denom_i;
    div_req_o.dividend = '0;

    unique case (state_q)
      wma_pkg::B_IDLE: begin
        if (clear_i) begin
          ptr_d   = '0;
          fill_d  = '0;
          plain_d = '0;
          wsum_d  = '0;
        end
        if (pop) begin
          cur_d  = q_i.item;
          prod_d = wma_pkg::PROD_W'(q_i.item.price) * wma_pkg::PROD_W'(mult);
          if (q_i.item.start_series) begin
            ptr_d   = '0;
            fill_d  = '0;
            plain_d = '0;
            wsum_d  = '0;
          end
          state_d = wma_pkg::B_UPDATE;
        end
      end
      wma_pkg::B_UPDATE: begin
        if (filling) begin
          plain_d = plain_q + wma_pkg::PLAIN_W'(cur_q.price);
          wsum_d  = wsum_q + wma_pkg::WSUM_W'(prod_q);
        end else begin
          plain_d = plain_q - wma_pkg::PLAIN_W'(oldest) + wma_pkg::PLAIN_W'(cur_q.price);
          wsum_d  = wsum_q - wma_pkg::WSUM_W'(plain_q) + wma_pkg::WSUM_W'(prod_q);
        end
        fill_d = fill_new;
        ptr_d  = (ptr_inc == len_i) ? '0 : PTR_W'(ptr_inc);
        if (fill_new == len_i) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = wsum_d;
          state_d            = wma_pkg::B_DIV;
        end else begin
          res_d   = '0;
          state_d = wma_pkg::B_OUT;
        end
      end
      wma_pkg::B_DIV: begin
        if (div_rsp_i.done) begin
          res_d.wma_value = div_rsp_i.quotient[wma_pkg::SAMPLE_W-1:0];
          res_d.valid_res = 1'b1;
          state_d         = wma_pkg::B_OUT;
        end
      end
      wma_pkg::B_OUT: begin
        if (!out_valid_q || m_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = wma_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = wma_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wma_pkg::B_IDLE;
      ptr_q       <= '0;
      fill_q      <= '0;
      plain_q     <= '0;
      wsum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
      plain_q     <= plain_d;
      wsum_q      <= wsum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    prod_q <= prod_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign m_valid_o  = out_valid_q;
  assign m_result_o = out_q;

  `WMA_ASSERT(a_fill_in_window, fill_q <= len_i, "fill count beyond window length")
  `WMA_ASSERT(a_ptr_in_window, ptr_ext < len_i, "window pointer beyond window length")
  `WMA_ASSERT_IMP(a_div_done_in_div, div_rsp_i.done, state_q == wma_pkg::B_DIV,
                  "divider finished outside the divide state")

endmodule

// ===== src/weighted_moving_average.sv =====
// Linear weighted moving average: top level with window length register.
//
// Usage:
//   Input channel s_axis: tdata carries price (unsigned, 16 fraction bits),
//   tuser carries start_series (1 restarts the window with this sample).
//   Output channel m_axis: one item per input item, tdata = wma_value,
//   tuser = valid_res. Until the window holds N samples an item with value 0
//   and valid_res 0 is returned.
//   Configuration: cfg_we_i writes cfg_wdata_i as window length N (0 reads as
//   1, values above MaxWindow saturate). A write also restarts the series.
//   Write only while no item is in flight.
// Flow:
//   A two-entry input queue keeps accepting while the back part works.
//   The back part takes one item at a time: an item passes the idle, update
//   and output states while the window fills; once it is full, the update
//   state also starts the bit-serial divider for the weighted sum and the
//   back part waits in the divide state until the quotient is done.
// Reset and stall:
//   Reset gives N = 1 and an empty window. A stalled m_axis holds its item in
//   the output register; the next result waits, then the queue fills and
//   s_axis_tready drops.
`timescale 1ns / 1ps
module weighted_moving_average #(
  parameter int MaxWindow = wma_pkg::MAX_WINDOW_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration
  input  logic                         cfg_we_i,
  input  logic [wma_pkg::LEN_W-1:0]    cfg_wdata_i,
  // Input channel
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [wma_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [31:0] price
  input  logic                         s_axis_tuser,  // [0] start_series
  // Output channel
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [wma_pkg::SAMPLE_W-1:0] m_axis_tdata,  // [31:0] wma_value
  output logic                         m_axis_tuser   // [0] valid_res
);

  localparam int PRODL_W = 2 * wma_pkg::LEN_W;

  logic [wma_pkg::LEN_W-1:0] len_q, len_d;
  logic [wma_pkg::DEN_W-1:0] denom_q, denom_d;
  logic [PRODL_W-1:0]        den_full;

  wma_pkg::item_t     s_item;
  wma_pkg::item_req_t q_head;
  logic               q_ready;
  wma_pkg::div_req_t  div_req;
  wma_pkg::div_rsp_t  div_rsp;
  wma_pkg::result_t   m_result;

  // Window length clamp and divisor N*(N+1)/2
  always_comb begin
    if (cfg_wdata_i == '0) begin
      len_d = wma_pkg::LEN_W'(1);
    end else if (32'(cfg_wdata_i) > 32'(MaxWindow)) begin
      len_d = wma_pkg::LEN_W'(MaxWindow);
    end else begin
      len_d = cfg_wdata_i;
    end
    den_full = PRODL_W'(len_d) * (PRODL_W'(len_d) + PRODL_W'(1));
    denom_d  = den_full[PRODL_W-1:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= wma_pkg::LEN_W'(1);
      denom_q <= wma_pkg::DEN_W'(1);
    end else if (cfg_we_i) begin
      len_q   <= len_d;
      denom_q <= denom_d;
    end
  end

  assign s_item.price        = s_axis_tdata;
  assign s_item.start_series = s_axis_tuser;

  wma_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .q_o       (q_head),
    .q_ready_i (q_ready)
  );

  wma_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  wma_core #(
    .MaxWindow (MaxWindow)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (cfg_we_i),
    .len_i      (len_q),
    .denom_i    (denom_q),
    .q_i        (q_head),
    .q_ready_o  (q_ready),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_result_o (m_result)
  );

  assign m_axis_tdata = m_result.wma_value;
  assign m_axis_tuser = m_result.valid_res;

endmodule

// ===== test/weighted_moving_average_tb.sv =====
// Self-checking testbench for the weighted moving average block.
`timescale 1ns / 1ps
module weighted_moving_average_tb;

  // Cycles to let pass before a register write and at the end of the run
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_SAMPLES = 1500;

  logic                         clk_i;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [wma_pkg::LEN_W-1:0]    cfg_wdata_i   = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [wma_pkg::SAMPLE_W-1:0] s_axis_tdata  = '0;  // [31:0] price
  logic                         s_axis_tuser  = 1'b0;  // [0] start_series
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [wma_pkg::SAMPLE_W-1:0] m_axis_tdata;  // [31:0] wma_value
  logic                         m_axis_tuser;  // [0] valid_res

  weighted_moving_average i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Predictor state: window length register and the running series
  logic [wma_pkg::LEN_W-1:0]    wma_len_reg = 9'd1;
  logic [wma_pkg::SAMPLE_W-1:0] wma_window [wma_pkg::MAX_WINDOW_DEF];
  int unsigned                  wma_ptr     = 0;
  int unsigned                  wma_fill    = 0;
  logic [wma_pkg::PLAIN_W-1:0]  wma_plain   = '0;
  logic [wma_pkg::WSUM_W-1:0]   wma_weighted = '0;

  // Averages still owed by the block, oldest first
  wma_pkg::result_t wma_expected[$];

  int error_count      = 0;
  int samples_sent     = 0;
  int results_checked  = 0;
  int averages_checked = 0;
  int windows_tried    = 0;
  int burst_left       = 0;
  int rx_left          = 0;
  logic rx_level       = 1'b1;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_error(input string line);
    error_count++;
    $display("%0t ERROR: %s", $time, line);
  endtask

  function automatic void restart_series();
    wma_ptr      = 0;
    wma_fill     = 0;
    wma_plain    = '0;
    wma_weighted = '0;
  endfunction

  // Window length as the block uses it: zero acts as one, large values saturate
  function automatic int unsigned window_span(input logic [wma_pkg::LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > wma_pkg::MAX_WINDOW_DEF) return wma_pkg::MAX_WINDOW_DEF;
    return 32'(len);
  endfunction

  // Update the running sums for one sample and queue the average it yields
  function automatic void predict_wma(input logic [wma_pkg::SAMPLE_W-1:0] price,
                                      input logic start);
    int unsigned                  n;
    int unsigned                  slot;
    logic [wma_pkg::SAMPLE_W-1:0] oldest;
    logic [wma_pkg::WSUM_W-1:0]   denom;
    logic [wma_pkg::WSUM_W-1:0]   quot;
    wma_pkg::result_t             res;
    n = window_span(wma_len_reg);
    if (start) restart_series();
    slot = wma_ptr % n;
    if (wma_fill < n) begin
      wma_fill++;
      wma_plain    = wma_plain + wma_pkg::PLAIN_W'(price);
      wma_weighted = wma_weighted
                   + wma_pkg::WSUM_W'(price) * wma_pkg::WSUM_W'(wma_fill);
    end else begin
      oldest       = wma_window[slot];
      wma_weighted = wma_weighted - wma_pkg::WSUM_W'(wma_plain)
                   + wma_pkg::WSUM_W'(price) * wma_pkg::WSUM_W'(n);
      wma_plain    = wma_plain - wma_pkg::PLAIN_W'(oldest) + wma_pkg::PLAIN_W'(price);
    end
    wma_window[slot] = price;
    wma_ptr = (slot + 1) % n;
    if (wma_fill < n) begin
      res.wma_value = '0;
      res.valid_res = 1'b0;
    end else begin
      denom = wma_pkg::WSUM_W'(n * (n + 1) / 2);
      quot  = wma_weighted / denom;
      res.wma_value = quot[wma_pkg::SAMPLE_W-1:0];
      res.valid_res = 1'b1;
    end
    wma_expected = {wma_expected, res};
  endfunction

  // Send one sample; gaps come between bursts of random length
  task automatic send_sample(input logic [wma_pkg::SAMPLE_W-1:0] price, input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= price;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    samples_sent++;
    predict_wma(price, start);
  endtask

  // Let every owed average come out, then some quiet cycles
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (wma_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write; it also restarts the series
  task automatic set_window(input logic [wma_pkg::LEN_W-1:0] len);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    wma_len_reg = len;
    restart_series();
    windows_tried++;
  endtask

  function automatic logic [wma_pkg::SAMPLE_W-1:0] random_price();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return wma_pkg::SAMPLE_W'($urandom_range(0, 255));
      4:       return {16'($urandom_range(0, 255)), 16'h0};
      default: return $urandom();
    endcase
  endfunction

  // Reset value of the window length is one: every sample is its own average
  task automatic test_default_window();
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(32'h0001_0000, 1'b1);
    send_sample(32'h8000_0001, 1'b0);
  endtask

  // Zero length, full-scale sums, saturated length
  task automatic test_window_extremes();
    set_window('0);
    send_sample(32'h1234_5678, 1'b0);
    send_sample('1, 1'b0);
    set_window(9'd2);
    send_sample('1, 1'b0);
    send_sample('1, 1'b0);
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    set_window('1);
    send_sample('1, 1'b0);
    send_sample(32'h0000_0001, 1'b1);
    send_sample('1, 1'b0);
  endtask

  // Start flag mid-series and a rewrite of the same length both refill the window
  task automatic test_series_restart();
    set_window(9'd3);
    send_sample(32'h0003_0000, 1'b0);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h0002_0000, 1'b0);
    send_sample(32'h0007_0000, 1'b0);
    send_sample(32'h0005_0000, 1'b1);
    send_sample(32'h0006_0000, 1'b0);
    send_sample(32'h0004_0000, 1'b0);
    send_sample(32'h0009_0000, 1'b0);
    set_window(9'd3);
    send_sample(32'h0000_0010, 1'b0);
    send_sample(32'h0000_0020, 1'b0);
    send_sample(32'h0000_0030, 1'b0);
  endtask

  // Series with random content over many window lengths, a few of them large
  task automatic test_random_windows();
    int unsigned               phase;
    int unsigned               sent;
    int unsigned               count;
    int unsigned               span;
    logic [wma_pkg::LEN_W-1:0] len;
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_SAMPLES) begin
      case (phase)
        2:       len = 9'd256;
        5:       len = '1;
        8:       len = wma_pkg::LEN_W'($urandom_range(257, 510));
        default: len = ($urandom_range(0, 4) == 0) ? wma_pkg::LEN_W'($urandom_range(13, 64))
                                                   : wma_pkg::LEN_W'($urandom_range(0, 12));
      endcase
      set_window(len);
      span  = window_span(len);
      count = span + $urandom_range(10, 60);
      repeat (count) begin
        send_sample(random_price(), (span <= 64) && ($urandom_range(0, 29) == 0));
      end
      sent += count;
      phase++;
    end
  endtask

  // Receiver: runs of steady ready mixed with short and long stalls
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      case ($urandom_range(0, 3))
        0:       begin rx_level = 1'b1; rx_left = $urandom_range(20, 80); end
        1:       begin rx_level = 1'b0; rx_left = $urandom_range(1, 16); end
        default: begin rx_level = ~rx_level; rx_left = $urandom_range(1, 6); end
      endcase
    end
    rx_left--;
    m_axis_tready <= rx_level;
  end

  // Compare each accepted average with the oldest one owed
  always @(posedge clk_i) begin
    wma_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (wma_expected.size() == 0) begin
        report_error($sformatf("average %0h valid %0b with none owed",
                               m_axis_tdata, m_axis_tuser));
      end else begin
        want = wma_expected.pop_front();
        results_checked++;
        if (want.valid_res) averages_checked++;
        if (m_axis_tuser !== want.valid_res)
          report_error($sformatf("valid_res got %0b want %0b", m_axis_tuser, want.valid_res));
        if (m_axis_tdata !== want.wma_value)
          report_error($sformatf("wma_value got %0h want %0h", m_axis_tdata, want.wma_value));
      end
    end
  end

  // Test sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_window();
    test_window_extremes();
    test_series_restart();
    test_random_windows();
    wait_drained();
    $display("%0d samples sent over %0d window settings", samples_sent, windows_tried);
    $display("%0d results compared, %0d of them full-window averages",
             results_checked, averages_checked);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6ms;
    $display("timeout with %0d averages still owed", wma_expected.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/wma_pkg.sv
src/wma_ram.sv
src/wma_front.sv
src/wma_div.sv
src/wma_core.sv
src/weighted_moving_average.sv
test/weighted_moving_average_tb.sv
